[design/tccw_pkg.sv]
// shared constants, types and address helper for the text console cell writer
package tccw_pkg;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int NUM_CELLS = COLUMNS * ROWS;
	localparam int ADDR_W    = $clog2(NUM_CELLS);
	localparam int CROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CCOL_W    = $clog2(COLUMNS + 1);

	localparam int MODE_W   = 3;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int ROW_IN_W = 5;
	localparam int COL_IN_W = 7;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT   = 3'd0,
		MODE_BACK  = 3'd1,
		MODE_SET   = 3'd2,
		MODE_CLEAR = 3'd3,
		MODE_READ  = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_PUT,
		ST_BS_RD,
		ST_BS_CHK,
		ST_BLANK,
		ST_RD,
		ST_DONE
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CROW_W-1:0] r,
			input logic [CCOL_W-1:0] c);
		return ADDR_W'(r * COLUMNS) + ADDR_W'(c);
	endfunction

endpackage

[design/text_console_cell_writer.sv]
// text console engine: cursor control and read-modify-write of the cell ram
//
// A word is taken only while the engine is idle. Set cursor, newline without scroll,
// backspace at the top-left corner and unused modes go straight to the done state; put
// character, read cell and backspace within a row first pass through a write or read state.
// The done state loads the result into the output register once that register is free.
// Backspace from column 0 scans the previous row from its last column, alternating a read
// state and a check state per cell. A newline on the last row scrolls the whole cell ram
// through its single write port, copying each row up and blanking the last row, and a
// character written after the wrap follows the scroll; clear screen blanks every cell. After
// reset the ram is blanked in a pass over all cells with in_ready low; cfg_we is taken at
// any time. A finished result waits in the output register while the next word is accepted.
module text_console_cell_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tccw_pkg::ATTR_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tccw_pkg::MODE_W-1:0]    mode,
	input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tccw_pkg::ROW_IN_W-1:0]  row_in,
	input  logic [tccw_pkg::COL_IN_W-1:0]  col_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tccw_pkg::ROW_IN_W-1:0]  cursor_row,
	output logic [tccw_pkg::COL_IN_W-1:0]  cursor_col,
	output logic [tccw_pkg::CHAR_W-1:0]    cell_char,
	output logic [tccw_pkg::ATTR_W-1:0]    cell_attr
);

	localparam logic [tccw_pkg::ADDR_W-1:0] LAST_CELL =
		tccw_pkg::ADDR_W'(tccw_pkg::NUM_CELLS - 1);
	localparam logic [tccw_pkg::ADDR_W-1:0] LAST_COPY =
		tccw_pkg::ADDR_W'(tccw_pkg::NUM_CELLS - tccw_pkg::COLUMNS - 1);
	localparam logic [tccw_pkg::ADDR_W-1:0] ROW_STRIDE =
		tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
	localparam logic [tccw_pkg::CROW_W-1:0] LAST_ROW = tccw_pkg::CROW_W'(tccw_pkg::ROWS - 1);
	localparam logic [tccw_pkg::CCOL_W-1:0] LAST_COL =
		tccw_pkg::CCOL_W'(tccw_pkg::COLUMNS - 1);
	localparam logic [tccw_pkg::CCOL_W-1:0] WRAP_COL = tccw_pkg::CCOL_W'(tccw_pkg::COLUMNS);

	tccw_pkg::state_t state_q, state_d;

	logic [tccw_pkg::ADDR_W-1:0] scan_q;
	logic [tccw_pkg::CROW_W-1:0] row_q;
	logic [tccw_pkg::CCOL_W-1:0] col_q;
	logic [tccw_pkg::ATTR_W-1:0] attr_q;
	logic                        put_after_q;
	logic [tccw_pkg::CHAR_W-1:0] char_q;
	tccw_pkg::mode_t             mode_q;
	logic [tccw_pkg::CROW_W-1:0] rrow_q;
	logic [tccw_pkg::CCOL_W-1:0] rcol_q;

	// write stage: every ram write issues in the cycle after it is decided
	logic                        wr_s1, wr_d;
	logic                        wcopy_s1, wcopy_d;
	logic [tccw_pkg::ADDR_W-1:0] waddr_s1, waddr_d;
	logic [tccw_pkg::CELL_W-1:0] wdata_s1, wdata_d;

	logic                        ram_re;
	logic [tccw_pkg::ADDR_W-1:0] ram_raddr;
	logic [tccw_pkg::CELL_W-1:0] ram_rdata;
	logic [tccw_pkg::CELL_W-1:0] ram_wdata;

	logic                          out_valid_q;
	logic                          load_out;
	logic [tccw_pkg::ROW_IN_W-1:0] cursor_row_q;
	logic [tccw_pkg::COL_IN_W-1:0] cursor_col_q;
	logic [tccw_pkg::CHAR_W-1:0]   cell_char_q;
	logic [tccw_pkg::ATTR_W-1:0]   cell_attr_q;

	logic                        accept;
	logic                        is_newline;
	logic                        nl_first;
	logic                        on_last_row;
	logic                        rd_space;
	logic [tccw_pkg::CROW_W-1:0] row_clamp;
	logic [tccw_pkg::CCOL_W-1:0] col_clamp;
	logic [tccw_pkg::CELL_W-1:0] blank;

	assign accept      = in_valid && in_ready;
	assign is_newline  = (char_code == tccw_pkg::NEWLINE_CODE);
	assign nl_first    = is_newline || (col_q >= WRAP_COL);
	assign on_last_row = (row_q == LAST_ROW);
	assign rd_space    = (ram_rdata[tccw_pkg::CHAR_W-1:0] == tccw_pkg::SPACE_CODE);
	assign row_clamp   = (int'(row_in) > tccw_pkg::ROWS - 1) ? LAST_ROW
		: tccw_pkg::CROW_W'(row_in);
	assign col_clamp   = (int'(col_in) > tccw_pkg::COLUMNS - 1) ? LAST_COL
		: tccw_pkg::CCOL_W'(col_in);
	assign blank       = {attr_q, tccw_pkg::SPACE_CODE};
	assign ram_wdata   = wcopy_s1 ? ram_rdata : wdata_s1;

	tccw_ram #(
		.WIDTH(tccw_pkg::CELL_W),
		.DEPTH(tccw_pkg::NUM_CELLS)
	) u_cells (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(waddr_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		wr_d      = 1'b0;
		wcopy_d   = 1'b0;
		waddr_d   = '0;
		wdata_d   = '0;
		load_out  = 1'b0;
		unique case (state_q)
			tccw_pkg::ST_INIT: begin
				wr_d    = 1'b1;
				waddr_d = scan_q;
				wdata_d = {tccw_pkg::RESET_ATTR, tccw_pkg::SPACE_CODE};
				if (scan_q == LAST_CELL) begin
					state_d = tccw_pkg::ST_IDLE;
				end
			end
			tccw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (tccw_pkg::mode_t'(mode))
						tccw_pkg::MODE_PUT: begin
							if (nl_first && on_last_row) begin
								state_d = tccw_pkg::ST_SCROLL;
							end else if (is_newline) begin
								state_d = tccw_pkg::ST_DONE;
							end else begin
								state_d = tccw_pkg::ST_PUT;
							end
						end
						tccw_pkg::MODE_BACK: begin
							if (col_q != '0) begin
								state_d = tccw_pkg::ST_BLANK;
							end else if (row_q != '0) begin
								state_d = tccw_pkg::ST_BS_RD;
							end else begin
								state_d = tccw_pkg::ST_DONE;
							end
						end
						tccw_pkg::MODE_CLEAR: state_d = tccw_pkg::ST_FILL;
						tccw_pkg::MODE_READ:  state_d = tccw_pkg::ST_RD;
						default:              state_d = tccw_pkg::ST_DONE;
					endcase
				end
			end
			tccw_pkg::ST_SCROLL: begin
				ram_re    = 1'b1;
				ram_raddr = scan_q + ROW_STRIDE;
				wr_d      = 1'b1;
				wcopy_d   = 1'b1;
				waddr_d   = scan_q;
				if (scan_q == LAST_COPY) begin
					state_d = tccw_pkg::ST_FILL;
				end
			end
			tccw_pkg::ST_FILL: begin
				wr_d    = 1'b1;
				waddr_d = scan_q;
				wdata_d = blank;
				if (scan_q == LAST_CELL) begin
					state_d = put_after_q ? tccw_pkg::ST_PUT : tccw_pkg::ST_DONE;
				end
			end
			tccw_pkg::ST_PUT: begin
				wr_d    = 1'b1;
				waddr_d = tccw_pkg::cell_addr(row_q, col_q);
				wdata_d = {attr_q, char_q};
				state_d = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_BS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = tccw_pkg::cell_addr(row_q, col_q);
				state_d   = tccw_pkg::ST_BS_CHK;
			end
			tccw_pkg::ST_BS_CHK: begin
				state_d = (rd_space && col_q != '0) ? tccw_pkg::ST_BS_RD : tccw_pkg::ST_BLANK;
			end
			tccw_pkg::ST_BLANK: begin
				wr_d    = 1'b1;
				waddr_d = tccw_pkg::cell_addr(row_q, col_q);
				wdata_d = blank;
				state_d = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = tccw_pkg::cell_addr(rrow_q, rcol_q);
				state_d   = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = tccw_pkg::ST_IDLE;
				end
			end
			default: state_d = tccw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			attr_q      <= tccw_pkg::RESET_ATTR;
			put_after_q <= 1'b0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1 <= wr_d;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tccw_pkg::ST_INIT, tccw_pkg::ST_SCROLL, tccw_pkg::ST_FILL: begin
					scan_q <= (scan_q == LAST_CELL) ? '0 : scan_q + 1'b1;
				end
				tccw_pkg::ST_IDLE: begin
					if (accept) begin
						scan_q      <= '0;
						put_after_q <= (tccw_pkg::mode_t'(mode) == tccw_pkg::MODE_PUT)
							&& !is_newline;
						unique case (tccw_pkg::mode_t'(mode))
							tccw_pkg::MODE_PUT: begin
								if (nl_first) begin
									col_q <= '0;
									if (!on_last_row) begin
										row_q <= row_q + 1'b1;
									end
								end
							end
							tccw_pkg::MODE_BACK: begin
								if (col_q != '0) begin
									col_q <= (col_q >= WRAP_COL) ? LAST_COL : col_q - 1'b1;
								end else if (row_q != '0) begin
									row_q <= row_q - 1'b1;
									col_q <= LAST_COL;
								end
							end
							tccw_pkg::MODE_SET: begin
								row_q <= row_clamp;
								col_q <= col_clamp;
							end
							tccw_pkg::MODE_CLEAR: begin
								row_q <= '0;
								col_q <= '0;
							end
							default: ;
						endcase
					end
				end
				tccw_pkg::ST_PUT: col_q <= col_q + 1'b1;
				tccw_pkg::ST_BS_CHK: begin
					if (rd_space && col_q != '0) begin
						col_q <= col_q - 1'b1;
					end else if (!rd_space && col_q < LAST_COL) begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		wcopy_s1 <= wcopy_d;
		waddr_s1 <= waddr_d;
		wdata_s1 <= wdata_d;
		if (accept) begin
			mode_q <= tccw_pkg::mode_t'(mode);
			char_q <= char_code;
			rrow_q <= row_clamp;
			rcol_q <= col_clamp;
		end
		if (load_out) begin
			cursor_row_q <= tccw_pkg::ROW_IN_W'(row_q);
			cursor_col_q <= tccw_pkg::COL_IN_W'(col_q);
			if (mode_q == tccw_pkg::MODE_READ) begin
				cell_char_q <= ram_rdata[tccw_pkg::CHAR_W-1:0];
				cell_attr_q <= ram_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
			end else begin
				cell_char_q <= '0;
				cell_attr_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

endmodule

[design/tccw_ram.sv]
// generic single write port ram with registered read
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/tccw_checker.sv]
// port-level checks for the text console cell writer and their bind
module tccw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tccw_pkg::ROW_IN_W-1:0]  cursor_row,
	input logic [tccw_pkg::COL_IN_W-1:0]  cursor_col,
	input logic [tccw_pkg::CHAR_W-1:0]    cell_char,
	input logic [tccw_pkg::ATTR_W-1:0]    cell_attr
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_row) && $stable(cursor_col)
			&& $stable(cell_char) && $stable(cell_attr))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the previous word finished");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(cursor_row) <= tccw_pkg::ROWS - 1)
		else $error("cursor row beyond last row");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(cursor_col) <= tccw_pkg::COLUMNS)
		else $error("cursor column beyond wrap column");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);

[bench/testbench.sv]
// self-checking testbench for the text console cell writer: directed, stall and random sessions
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [tccw_pkg::ROW_IN_W-1:0] row;
		logic [tccw_pkg::COL_IN_W-1:0] col;
		logic [tccw_pkg::CHAR_W-1:0]   ch;
		logic [tccw_pkg::ATTR_W-1:0]   attr;
	} console_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [tccw_pkg::ATTR_W-1:0]   cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [tccw_pkg::MODE_W-1:0]   mode = '0;
	logic [tccw_pkg::CHAR_W-1:0]   char_code = '0;
	logic [tccw_pkg::ROW_IN_W-1:0] row_in = '0;
	logic [tccw_pkg::COL_IN_W-1:0] col_in = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [tccw_pkg::ROW_IN_W-1:0] cursor_row;
	logic [tccw_pkg::COL_IN_W-1:0] cursor_col;
	logic [tccw_pkg::CHAR_W-1:0]   cell_char;
	logic [tccw_pkg::ATTR_W-1:0]   cell_attr;

	logic [tccw_pkg::CELL_W-1:0] screen [tccw_pkg::NUM_CELLS];
	logic [tccw_pkg::ATTR_W-1:0] attr_now;
	int crow, ccol;
	console_result_t expected_q[$];
	int errors, words_in, results_seen, scrolls, wraps, clears, row_backs, attr_writes;
	int sender_idle_pct, recv_stall_pct, hold_left, quiet_cycles;

	text_console_cell_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.char_code  (char_code),
		.row_in     (row_in),
		.col_in     (col_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr)
	);

	always #5 clk = ~clk;

	function automatic logic [tccw_pkg::CELL_W-1:0] blank_cell();
		return {attr_now, tccw_pkg::SPACE_CODE};
	endfunction

	function automatic void next_line();
		ccol = 0;
		if (crow < tccw_pkg::ROWS - 1) begin
			crow++;
		end else begin
			for (int i = 0; i < tccw_pkg::NUM_CELLS - tccw_pkg::COLUMNS; i++) begin
				screen[i] = screen[i + tccw_pkg::COLUMNS];
			end
			for (int c = 0; c < tccw_pkg::COLUMNS; c++) begin
				screen[(tccw_pkg::ROWS - 1) * tccw_pkg::COLUMNS + c] = blank_cell();
			end
			scrolls++;
		end
	endfunction

	function automatic void back_step();
		int c;
		if (ccol > 0) begin
			if (ccol > tccw_pkg::COLUMNS) begin
				ccol = tccw_pkg::COLUMNS;
			end
			ccol--;
		end else if (crow > 0) begin
			crow--;
			c = tccw_pkg::COLUMNS - 1;
			while (c > 0 && screen[crow * tccw_pkg::COLUMNS + c][tccw_pkg::CHAR_W-1:0]
					== tccw_pkg::SPACE_CODE) c--;
			if (screen[crow * tccw_pkg::COLUMNS + c][tccw_pkg::CHAR_W-1:0]
					!= tccw_pkg::SPACE_CODE && c < tccw_pkg::COLUMNS - 1) begin
				c++;
			end
			ccol = c;
			row_backs++;
		end else begin
			return;
		end
		screen[crow * tccw_pkg::COLUMNS + ccol] = blank_cell();
	endfunction

	function automatic console_result_t console_apply(logic [tccw_pkg::MODE_W-1:0] m,
			logic [tccw_pkg::CHAR_W-1:0] ch, logic [tccw_pkg::ROW_IN_W-1:0] r_in,
			logic [tccw_pkg::COL_IN_W-1:0] c_in);
		console_result_t res;
		int r, c;
		r = (r_in > tccw_pkg::ROWS - 1) ? tccw_pkg::ROWS - 1 : int'(r_in);
		c = (c_in > tccw_pkg::COLUMNS - 1) ? tccw_pkg::COLUMNS - 1 : int'(c_in);
		res = '0;
		case (m)
			tccw_pkg::MODE_PUT: begin
				if (ch == tccw_pkg::NEWLINE_CODE) begin
					next_line();
				end else begin
					if (ccol >= tccw_pkg::COLUMNS) begin
						next_line();
						wraps++;
					end
					screen[crow * tccw_pkg::COLUMNS + ccol] = {attr_now, ch};
					ccol++;
				end
			end
			tccw_pkg::MODE_BACK: begin
				back_step();
			end
			tccw_pkg::MODE_SET: begin
				crow = r;
				ccol = c;
			end
			tccw_pkg::MODE_CLEAR: begin
				for (int i = 0; i < tccw_pkg::NUM_CELLS; i++) screen[i] = blank_cell();
				crow = 0;
				ccol = 0;
				clears++;
			end
			tccw_pkg::MODE_READ: begin
				res.ch   = screen[r * tccw_pkg::COLUMNS + c][tccw_pkg::CHAR_W-1:0];
				res.attr = screen[r * tccw_pkg::COLUMNS + c][tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
			end
			default: begin
			end
		endcase
		res.row = tccw_pkg::ROW_IN_W'(crow);
		res.col = tccw_pkg::COL_IN_W'(ccol);
		return res;
	endfunction

	function automatic logic [tccw_pkg::CHAR_W-1:0] text_byte();
		int pick;
		pick = $urandom_range(15);
		if (pick < 2) begin
			return tccw_pkg::NEWLINE_CODE;
		end else if (pick < 4) begin
			return tccw_pkg::SPACE_CODE;
		end
		return tccw_pkg::CHAR_W'($urandom_range(255));
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic send_word(logic [tccw_pkg::MODE_W-1:0] m, logic [tccw_pkg::CHAR_W-1:0] ch,
			logic [tccw_pkg::ROW_IN_W-1:0] r, logic [tccw_pkg::COL_IN_W-1:0] c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		char_code <= ch;
		row_in    <= r;
		col_in    <= c;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(console_apply(m, ch, r, c));
		words_in++;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_text_attr(logic [tccw_pkg::ATTR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		attr_now = value;
		attr_writes++;
	endtask

	task automatic test_edge_cases();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd31, 7'd127);
		send_word(tccw_pkg::MODE_PUT, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_PUT, 8'hFF, 5'd31, 7'd127);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		// clamp to the bottom-right cell, then wrap with scroll
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd31, 7'd127);
		send_word(tccw_pkg::MODE_PUT, 8'h41, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_PUT, 8'h42, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd23, 7'd79);
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd24, 7'd79);
		send_word(tccw_pkg::MODE_PUT, 8'h43, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_PUT, tccw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		// backspace while wrap pending
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd0, 7'd79);
		send_word(tccw_pkg::MODE_PUT, 8'h44, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		// row above full to its last column
		send_word(tccw_pkg::MODE_PUT, 8'h45, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd1, 7'd0);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		// row above all spaces
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd9, 7'd0);
		send_word(tccw_pkg::MODE_BACK, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_W'(5), 8'h5A, 5'd3, 7'd3);
		send_word(tccw_pkg::MODE_W'(7), 8'hA5, 5'd28, 7'd124);
		pause_until_drained();
	endtask

	task automatic test_attr_extremes();
		set_text_attr(8'h00);
		send_word(tccw_pkg::MODE_PUT, 8'h78, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_READ, 8'h00, tccw_pkg::ROW_IN_W'(crow),
			tccw_pkg::COL_IN_W'(ccol - 1));
		pause_until_drained();
		set_text_attr(8'hFF);
		send_word(tccw_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd12, 7'd40);
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd24, 7'd3);
		send_word(tccw_pkg::MODE_PUT, tccw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd24, 7'd0);
		pause_until_drained();
	endtask

	task automatic test_output_hold();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left = HOLD_CYCLES;
		send_word(tccw_pkg::MODE_SET, 8'h00, 5'd24, 7'd70);
		for (int k = 0; k < 12; k++) begin
			send_word(tccw_pkg::MODE_PUT,
				(k == 6) ? tccw_pkg::NEWLINE_CODE : tccw_pkg::CHAR_W'(8'h61 + k), 5'd0, 7'd0);
		end
		send_word(tccw_pkg::MODE_READ, 8'h00, 5'd23, 7'd75);
		pause_until_drained();
	endtask

	task automatic test_random_session(int words, int s_idle, int r_stall);
		int sent, kind, run, r, c;
		sender_idle_pct = s_idle;
		recv_stall_pct  = r_stall;
		sent = 0;
		while (sent < words) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				run = $urandom_range(30, 3);
				for (int k = 0; k < run; k++) begin
					send_word(tccw_pkg::MODE_PUT, text_byte(),
						tccw_pkg::ROW_IN_W'($urandom_range(31)),
						tccw_pkg::COL_IN_W'($urandom_range(127)));
				end
				sent += run;
			end else if (kind < 60) begin
				run = $urandom_range(4, 1);
				for (int k = 0; k < run; k++) begin
					send_word(tccw_pkg::MODE_BACK, tccw_pkg::CHAR_W'($urandom_range(255)),
						tccw_pkg::ROW_IN_W'($urandom_range(31)),
						tccw_pkg::COL_IN_W'($urandom_range(127)));
				end
				sent += run;
			end else if (kind < 72) begin
				// favor the bottom rows, line starts and line ends
				r = ($urandom_range(2) == 0) ? $urandom_range(31, 22) : $urandom_range(31);
				case ($urandom_range(3))
					0: c = 0;
					1: c = $urandom_range(127, 76);
					default: c = $urandom_range(127);
				endcase
				send_word(tccw_pkg::MODE_SET, tccw_pkg::CHAR_W'($urandom_range(255)),
					tccw_pkg::ROW_IN_W'(r), tccw_pkg::COL_IN_W'(c));
				sent++;
			end else if (kind < 88) begin
				r = ($urandom_range(1) == 0) ? crow : $urandom_range(31);
				send_word(tccw_pkg::MODE_READ, tccw_pkg::CHAR_W'($urandom_range(255)),
					tccw_pkg::ROW_IN_W'(r), tccw_pkg::COL_IN_W'($urandom_range(127)));
				sent++;
			end else if (kind < 91) begin
				send_word(tccw_pkg::MODE_CLEAR, tccw_pkg::CHAR_W'($urandom_range(255)),
					tccw_pkg::ROW_IN_W'($urandom_range(31)),
					tccw_pkg::COL_IN_W'($urandom_range(127)));
				sent++;
			end else begin
				send_word(tccw_pkg::MODE_W'($urandom_range(7)),
					tccw_pkg::CHAR_W'($urandom_range(255)),
					tccw_pkg::ROW_IN_W'($urandom_range(31)),
					tccw_pkg::COL_IN_W'($urandom_range(127)));
				sent++;
			end
		end
		pause_until_drained();
	endtask

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result row %0d col %0d with nothing expected",
					cursor_row, cursor_col));
			end else begin
				want = expected_q.pop_front();
				if ({cursor_row, cursor_col, cell_char, cell_attr} !== want) begin
					report_mismatch($sformatf(
						"got row %0d col %0d char %02h attr %02h, want %0d %0d %02h %02h",
						cursor_row, cursor_col, cell_char, cell_attr,
						want.row, want.col, want.ch, want.attr));
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		for (int i = 0; i < tccw_pkg::NUM_CELLS; i++) begin
			screen[i] = {tccw_pkg::RESET_ATTR, tccw_pkg::SPACE_CODE};
		end
		attr_now = tccw_pkg::RESET_ATTR;
		crow = 0;
		ccol = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_cases();
		test_attr_extremes();
		test_output_hold();
		set_text_attr(8'h1E);
		test_random_session(70, 0, 0);
		set_text_attr(tccw_pkg::ATTR_W'($urandom_range(255)));
		test_random_session(70, 52, 0);
		set_text_attr(8'h70);
		test_random_session(70, 0, 52);
		set_text_attr(tccw_pkg::RESET_ATTR);
		test_random_session(70, 18, 18);
		repeat (50) @(posedge clk);
		$display("run covered %0d words and %0d results under %0d attribute writes",
			words_in, results_seen, attr_writes);
		$display("including %0d scrolls, %0d wraps, %0d clears, %0d backspaces to the row above",
			scrolls, wraps, clears, row_backs);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
